[sv/ple_pkg.sv]
// ple_pkg: shared types and codes for the positional list engine.
// No dependencies; used by ple_cell, ple_ctrl and positional_list_engine_core.
`default_nettype none

package ple_pkg;

    localparam int ACTION_W = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 8;
    localparam int STATUS_W = 2;
    localparam int CNT_W    = 5;
    localparam int SLOT_W   = 8;

    localparam logic [ACTION_W-1:0] ACT_INS_FIRST = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_INS_LAST  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_INS_AT    = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_DEL_FIRST = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_DEL_LAST  = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_DEL_AT    = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_READ      = 3'd6;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd3;

    typedef enum logic [1:0] {
        CELL_NOP  = 2'd0,
        CELL_INS  = 2'd1,
        CELL_DEL  = 2'd2,
        CELL_READ = 2'd3
    } t_cell_op;

    typedef struct packed {
        t_cell_op                   op;
        logic [SLOT_W-1:0]          slot;
        logic signed [VALUE_W-1:0]  value;
    } t_cell_cmd;

endpackage

`default_nettype wire

[sv/ple_cell.sv]
// ple_cell: one list slot; shifts toward or away from its neighbors on command.
// Depends on ple_pkg.
`default_nettype none

module ple_cell #(
    parameter int INDEX = 0
) (
    input  wire logic                              i_clk,
    input  wire ple_pkg::t_cell_cmd                i_cmd,
    input  wire logic signed [ple_pkg::VALUE_W-1:0] i_left,
    input  wire logic signed [ple_pkg::VALUE_W-1:0] i_right,
    output logic signed [ple_pkg::VALUE_W-1:0]      o_value,
    output logic signed [ple_pkg::VALUE_W-1:0]      o_rd_data
);

    localparam logic [ple_pkg::SLOT_W-1:0] IDX = ple_pkg::SLOT_W'(INDEX);

    logic signed [ple_pkg::VALUE_W-1:0] r_value;
    logic signed [ple_pkg::VALUE_W-1:0] n_value;

    always_comb begin
        n_value = r_value;
        case (i_cmd.op)
            ple_pkg::CELL_INS: begin
                if (IDX == i_cmd.slot) begin
                    n_value = i_cmd.value;
                end else if (IDX > i_cmd.slot) begin
                    n_value = i_left;
                end
            end
            ple_pkg::CELL_DEL: begin
                if (IDX >= i_cmd.slot) begin
                    n_value = i_right;
                end
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value   = r_value;
    assign o_rd_data = (i_cmd.op == ple_pkg::CELL_READ && IDX == i_cmd.slot) ?
                       r_value : '0;

endmodule

`default_nettype wire

[sv/ple_ctrl.sv]
// ple_ctrl: decodes a request against the count into status, next count and cell command.
// Depends on ple_pkg.
`default_nettype none

module ple_ctrl #(
    parameter int LIST_DEPTH = 16,
    localparam int CW = $clog2(LIST_DEPTH + 1)
) (
    input  wire logic                               i_fire,
    input  wire logic [ple_pkg::ACTION_W-1:0]       i_action,
    input  wire logic signed [ple_pkg::VALUE_W-1:0] i_value,
    input  wire logic [ple_pkg::POS_W-1:0]          i_position,
    input  wire logic [CW-1:0]                      i_count,
    output ple_pkg::t_cell_cmd                      o_cmd,
    output logic [ple_pkg::STATUS_W-1:0]            o_status,
    output logic [CW-1:0]                           o_count_next,
    output logic [ple_pkg::CNT_W-1:0]               o_count_field
);

    localparam int CMPW = (CW > 9) ? CW : 9;

    logic [CMPW-1:0]            w_cnt;
    logic [CMPW-1:0]            w_pos;
    logic [CMPW-1:0]            w_next_ext;
    logic                       w_pos_zero;
    logic [ple_pkg::SLOT_W-1:0] w_pos_slot;
    ple_pkg::t_cell_op          w_op;
    logic [ple_pkg::SLOT_W-1:0] w_slot;

    assign w_cnt      = CMPW'(i_count);
    assign w_pos      = CMPW'(i_position);
    assign w_pos_zero = (i_position == '0);
    assign w_pos_slot = ple_pkg::SLOT_W'(i_position - ple_pkg::POS_W'(1));

    always_comb begin
        o_status     = ple_pkg::ST_OK;
        o_count_next = i_count;
        w_op         = ple_pkg::CELL_NOP;
        w_slot       = '0;
        case (i_action)
            ple_pkg::ACT_INS_FIRST, ple_pkg::ACT_INS_LAST, ple_pkg::ACT_INS_AT: begin
                if (i_action == ple_pkg::ACT_INS_AT &&
                    (w_pos_zero || w_pos > w_cnt + CMPW'(1))) begin
                    o_status = ple_pkg::ST_BADPOS;
                end else if (w_cnt == CMPW'(LIST_DEPTH)) begin
                    o_status = ple_pkg::ST_FULL;
                end else begin
                    w_op = ple_pkg::CELL_INS;
                    if (i_action == ple_pkg::ACT_INS_FIRST) begin
                        w_slot = '0;
                    end else if (i_action == ple_pkg::ACT_INS_LAST) begin
                        w_slot = ple_pkg::SLOT_W'(i_count);
                    end else begin
                        w_slot = w_pos_slot;
                    end
                    o_count_next = i_count + CW'(1);
                end
            end
            ple_pkg::ACT_DEL_FIRST, ple_pkg::ACT_DEL_LAST, ple_pkg::ACT_DEL_AT: begin
                if (w_cnt == '0) begin
                    o_status = ple_pkg::ST_EMPTY;
                end else if (i_action == ple_pkg::ACT_DEL_AT &&
                             (w_pos_zero || w_pos > w_cnt)) begin
                    o_status = ple_pkg::ST_BADPOS;
                end else begin
                    w_op = ple_pkg::CELL_DEL;
                    if (i_action == ple_pkg::ACT_DEL_FIRST) begin
                        w_slot = '0;
                    end else if (i_action == ple_pkg::ACT_DEL_LAST) begin
                        w_slot = ple_pkg::SLOT_W'(i_count - CW'(1));
                    end else begin
                        w_slot = w_pos_slot;
                    end
                    o_count_next = i_count - CW'(1);
                end
            end
            ple_pkg::ACT_READ: begin
                if (w_pos_zero || w_pos > w_cnt) begin
                    o_status = ple_pkg::ST_BADPOS;
                end else begin
                    w_op   = ple_pkg::CELL_READ;
                    w_slot = w_pos_slot;
                end
            end
            default: begin
                o_status = ple_pkg::ST_OK;
            end
        endcase
    end

    // state changes only on an accepted transaction
    always_comb begin
        o_cmd.op    = (i_fire || w_op == ple_pkg::CELL_READ) ? w_op : ple_pkg::CELL_NOP;
        o_cmd.slot  = w_slot;
        o_cmd.value = i_value;
    end

    assign w_next_ext    = CMPW'(o_count_next);
    assign o_count_field = w_next_ext[ple_pkg::CNT_W-1:0];

endmodule

`default_nettype wire

[sv/positional_list_engine_core.sv]
// positional_list_engine_core: bounded ordered list held in a row of shifting cells.
// Result is registered on acceptance; cells from the slot onward update in parallel.
// Throughput: one transaction per cycle while the output is not stalled.
// Reset clears the element count and the result valid; cell contents stay undefined.
// Depends on ple_pkg, ple_ctrl and ple_cell.
`default_nettype none

module positional_list_engine_core #(
    parameter int LIST_DEPTH = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic [ple_pkg::ACTION_W-1:0]       i_action,
    input  wire logic signed [ple_pkg::VALUE_W-1:0] i_value,
    input  wire logic [ple_pkg::POS_W-1:0]          i_position,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic [ple_pkg::STATUS_W-1:0]            o_status,
    output logic [ple_pkg::CNT_W-1:0]               o_element_count,
    output logic signed [ple_pkg::VALUE_W-1:0]      o_read_value
);

    localparam int CW = $clog2(LIST_DEPTH + 1);

    logic                               w_fire;
    ple_pkg::t_cell_cmd                 w_cmd;
    logic [ple_pkg::STATUS_W-1:0]       w_status;
    logic [CW-1:0]                      w_count_next;
    logic [ple_pkg::CNT_W-1:0]          w_count_field;
    logic signed [ple_pkg::VALUE_W-1:0] w_cell_val [LIST_DEPTH];
    logic signed [ple_pkg::VALUE_W-1:0] w_cell_rd  [LIST_DEPTH];
    logic signed [ple_pkg::VALUE_W-1:0] w_rd;

    logic [CW-1:0]                      r_count;
    logic                               r_out_valid;
    logic [ple_pkg::STATUS_W-1:0]       r_status;
    logic [ple_pkg::CNT_W-1:0]          r_count_out;
    logic signed [ple_pkg::VALUE_W-1:0] r_rd;

    assign o_in_ready = i_rst_n && (!r_out_valid || i_out_ready);
    assign w_fire     = i_in_valid && o_in_ready;

    ple_ctrl #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_ctrl (
        .i_fire        (w_fire),
        .i_action      (i_action),
        .i_value       (i_value),
        .i_position    (i_position),
        .i_count       (r_count),
        .o_cmd         (w_cmd),
        .o_status      (w_status),
        .o_count_next  (w_count_next),
        .o_count_field (w_count_field)
    );

    for (genvar k = 0; k < LIST_DEPTH; k++) begin : g_cell
        logic signed [ple_pkg::VALUE_W-1:0] w_left;
        logic signed [ple_pkg::VALUE_W-1:0] w_right;

        if (k == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_cell_val[k-1];
        end

        if (k == LIST_DEPTH - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_cell_val[k+1];
        end

        ple_cell #(
            .INDEX (k)
        ) u_cell (
            .i_clk     (i_clk),
            .i_cmd     (w_cmd),
            .i_left    (w_left),
            .i_right   (w_right),
            .o_value   (w_cell_val[k]),
            .o_rd_data (w_cell_rd[k])
        );
    end

    always_comb begin
        w_rd = '0;
        for (int k = 0; k < LIST_DEPTH; k++) begin
            w_rd = w_rd | w_cell_rd[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_count     <= w_count_next;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_status    <= w_status;
            r_count_out <= w_count_field;
            r_rd        <= w_rd;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_element_count = r_count_out;
    assign o_read_value    = r_rd;

endmodule

`default_nettype wire

[tb/testbench.sv]
// testbench: checks positional_list_engine_core with a directed table, then random request
// phases scored against a local copy of the list. Uses ple_pkg for widths and codes.
`default_nettype none

module testbench;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DEPTH       = 16;
    localparam int MAX_REPORTS = 10;
    localparam logic [ple_pkg::ACTION_W-1:0] ACT_UNUSED = 3'd7;

    localparam int MIX_FILL  = 0;
    localparam int MIX_DRAIN = 1;
    localparam int MIX_EVEN  = 2;

    typedef struct packed {
        logic [ple_pkg::STATUS_W-1:0]       status;
        logic [ple_pkg::CNT_W-1:0]          count;
        logic signed [ple_pkg::VALUE_W-1:0] rd;
    } t_list_result;

    typedef struct packed {
        logic                               typed;
        t_list_result                       fixed;
    } t_pend_entry;

    typedef struct packed {
        logic [ple_pkg::ACTION_W-1:0]       act;
        logic signed [ple_pkg::VALUE_W-1:0] val;
        logic [ple_pkg::POS_W-1:0]          pos;
        logic                               typed;
        t_list_result                       fixed;
    } t_dir_row;

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               i_in_valid;
    logic                               o_in_ready;
    logic [ple_pkg::ACTION_W-1:0]       i_action;
    logic signed [ple_pkg::VALUE_W-1:0] i_value;
    logic [ple_pkg::POS_W-1:0]          i_position;
    logic                               o_out_valid;
    logic                               i_out_ready;
    logic [ple_pkg::STATUS_W-1:0]       o_status;
    logic [ple_pkg::CNT_W-1:0]          o_element_count;
    logic signed [ple_pkg::VALUE_W-1:0] o_read_value;

    positional_list_engine_core #(.LIST_DEPTH(DEPTH)) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_action        (i_action),
        .i_value         (i_value),
        .i_position      (i_position),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_element_count (o_element_count),
        .o_read_value    (o_read_value)
    );

    // shadow list
    logic signed [ple_pkg::VALUE_W-1:0] list_mem [DEPTH];
    int                                 list_len;

    t_pend_entry  pend_q [$];
    t_list_result result_q [$];
    t_dir_row     dir_q [$];

    int           mismatch_count;
    int           cycle_count;
    bit           tx_idle_on;
    bit           rx_idle_on;
    int           rx_hold;
    t_pend_entry  acc_row;
    t_list_result acc_pred;
    t_list_result acc_exp;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic t_list_result apply_request(
        input logic [ple_pkg::ACTION_W-1:0] act,
        input logic signed [ple_pkg::VALUE_W-1:0] val,
        input logic [ple_pkg::POS_W-1:0] pos);
        t_list_result r;
        int           slot;
        int           p;
        p        = int'(pos);
        r.status = ple_pkg::ST_OK;
        r.rd     = '0;
        case (act)
            ple_pkg::ACT_INS_FIRST, ple_pkg::ACT_INS_LAST, ple_pkg::ACT_INS_AT: begin
                if (act == ple_pkg::ACT_INS_AT && (p < 1 || p > list_len + 1)) begin
                    r.status = ple_pkg::ST_BADPOS;
                end else if (list_len >= DEPTH) begin
                    r.status = ple_pkg::ST_FULL;
                end else begin
                    if (act == ple_pkg::ACT_INS_FIRST)
                        slot = 0;
                    else if (act == ple_pkg::ACT_INS_LAST)
                        slot = list_len;
                    else
                        slot = p - 1;
                    for (int i = list_len; i > slot; i--)
                        list_mem[i] = list_mem[i-1];
                    list_mem[slot] = val;
                    list_len++;
                end
            end
            ple_pkg::ACT_DEL_FIRST, ple_pkg::ACT_DEL_LAST, ple_pkg::ACT_DEL_AT: begin
                if (list_len == 0) begin
                    r.status = ple_pkg::ST_EMPTY;
                end else if (act == ple_pkg::ACT_DEL_AT && (p < 1 || p > list_len)) begin
                    r.status = ple_pkg::ST_BADPOS;
                end else begin
                    if (act == ple_pkg::ACT_DEL_FIRST)
                        slot = 0;
                    else if (act == ple_pkg::ACT_DEL_LAST)
                        slot = list_len - 1;
                    else
                        slot = p - 1;
                    for (int i = slot; i + 1 < list_len; i++)
                        list_mem[i] = list_mem[i+1];
                    list_len--;
                end
            end
            ple_pkg::ACT_READ: begin
                if (p < 1 || p > list_len)
                    r.status = ple_pkg::ST_BADPOS;
                else
                    r.rd = list_mem[p-1];
            end
            default: ;
        endcase
        r.count = list_len[ple_pkg::CNT_W-1:0];
        return r;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    function automatic t_list_result mk_result(input logic [ple_pkg::STATUS_W-1:0] st,
                                               input int cnt,
                                               input logic signed [ple_pkg::VALUE_W-1:0] rd);
        t_list_result r;
        r.status = st;
        r.count  = cnt[ple_pkg::CNT_W-1:0];
        r.rd     = rd;
        return r;
    endfunction

    function automatic void add_row(input logic [ple_pkg::ACTION_W-1:0] act,
                                    input logic signed [ple_pkg::VALUE_W-1:0] val,
                                    input int pos,
                                    input logic typed,
                                    input t_list_result fixed);
        t_dir_row row;
        row.act   = act;
        row.val   = val;
        row.pos   = pos[ple_pkg::POS_W-1:0];
        row.typed = typed;
        row.fixed = fixed;
        dir_q.push_back(row);
    endfunction

    task automatic offer(input logic [ple_pkg::ACTION_W-1:0] act,
                         input logic signed [ple_pkg::VALUE_W-1:0] val,
                         input logic [ple_pkg::POS_W-1:0] pos,
                         input logic typed,
                         input t_list_result fixed);
        int          gap;
        t_pend_entry entry;
        gap = tx_idle_on ? gap_len() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        entry.typed = typed;
        entry.fixed = fixed;
        pend_q.push_back(entry);
        i_action   <= act;
        i_value    <= val;
        i_position <= pos;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic offer_random(input int mix);
        logic [ple_pkg::ACTION_W-1:0]       act;
        logic signed [ple_pkg::VALUE_W-1:0] val;
        int                                 pos;
        int                                 r;
        int                                 ins_pct;
        int                                 rd_pct;
        ins_pct = (mix == MIX_FILL) ? 70 : (mix == MIX_DRAIN) ? 25 : 45;
        rd_pct  = ins_pct + ((mix == MIX_EVEN) ? 20 : 15);
        r = $urandom_range(0, 99);
        if (r < ins_pct)
            act = ple_pkg::ACTION_W'($urandom_range(ple_pkg::ACT_INS_FIRST,
                                                    ple_pkg::ACT_INS_AT));
        else if (r < rd_pct)
            act = ple_pkg::ACT_READ;
        else if (r < 97)
            act = ple_pkg::ACTION_W'($urandom_range(ple_pkg::ACT_DEL_FIRST,
                                                    ple_pkg::ACT_DEL_AT));
        else
            act = ACT_UNUSED;
        r = $urandom_range(0, 99);
        if (r < 85) begin
            val = $urandom;
        end else begin
            case ($urandom_range(0, 3))
                0:       val = 32'sh7fffffff;
                1:       val = 32'sh80000000;
                2:       val = -32'sd1;
                default: val = '0;
            endcase
        end
        r = $urandom_range(0, 99);
        if (r < 75) begin
            pos = $urandom_range(0, list_len + 1);
        end else if (r < 90) begin
            pos = $urandom_range(0, 255);
        end else begin
            case ($urandom_range(0, 3))
                0:       pos = 0;
                1:       pos = 255;
                2:       pos = list_len;
                default: pos = list_len + 1;
            endcase
        end
        offer(act, val, pos[ple_pkg::POS_W-1:0], 1'b0, '0);
    endtask

    task automatic wait_drained();
        while (result_q.size() != 0 || pend_q.size() != 0)
            @(posedge i_clk);
    endtask

    // scoreboard: check outgoing transaction first, then record the incoming one
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (result_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("unexpected result: status %0d count %0d read %0d",
                                 o_status, o_element_count, o_read_value);
                end else begin
                    acc_exp = result_q.pop_front();
                    if (o_status !== acc_exp.status || o_element_count !== acc_exp.count
                            || o_read_value !== acc_exp.rd) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("result mismatch: exp %0d/%0d/%0d got %0d/%0d/%0d",
                                     acc_exp.status, acc_exp.count, acc_exp.rd,
                                     o_status, o_element_count, o_read_value);
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                acc_row  = pend_q.pop_front();
                acc_pred = apply_request(i_action, i_value, i_position);
                result_q.push_back(acc_row.typed ? acc_row.fixed : acc_pred);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        int n;
        i_out_ready = 1'b0;
        @(posedge i_clk);
        forever begin
            if (rx_hold > 0) begin
                n       = rx_hold;
                rx_hold = 0;
                i_out_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end else if (rx_idle_on && $urandom_range(0, 99) < 20) begin
                n = gap_len();
                i_out_ready <= 1'b0;
                repeat (n + 1) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_action       = '0;
        i_value        = '0;
        i_position     = '0;
        list_len       = 0;
        mismatch_count = 0;
        cycle_count    = 0;
        tx_idle_on     = 1'b1;
        rx_idle_on     = 1'b1;
        rx_hold        = 0;
        for (int i = 0; i < DEPTH; i++)
            list_mem[i] = '0;

        add_row(ple_pkg::ACT_READ,      '0, 1, 1'b1,
                mk_result(ple_pkg::ST_BADPOS, 0, '0));
        add_row(ple_pkg::ACT_DEL_FIRST, '0, 0, 1'b1,
                mk_result(ple_pkg::ST_EMPTY, 0, '0));
        add_row(ple_pkg::ACT_DEL_LAST,  '0, 0, 1'b1,
                mk_result(ple_pkg::ST_EMPTY, 0, '0));
        add_row(ple_pkg::ACT_DEL_AT,    '0, 1, 1'b1,
                mk_result(ple_pkg::ST_EMPTY, 0, '0));
        add_row(ple_pkg::ACT_INS_AT,    32'sd5, 0, 1'b1,
                mk_result(ple_pkg::ST_BADPOS, 0, '0));
        add_row(ple_pkg::ACT_INS_AT,    32'sd5, 2, 1'b1,
                mk_result(ple_pkg::ST_BADPOS, 0, '0));
        add_row(ple_pkg::ACT_INS_FIRST, 32'sh7fffffff, 0, 1'b1,
                mk_result(ple_pkg::ST_OK, 1, '0));
        add_row(ple_pkg::ACT_INS_LAST,  32'sh80000000, 0, 1'b1,
                mk_result(ple_pkg::ST_OK, 2, '0));
        add_row(ple_pkg::ACT_READ,      '0, 1, 1'b1,
                mk_result(ple_pkg::ST_OK, 2, 32'sh7fffffff));
        add_row(ple_pkg::ACT_READ,      '0, 2, 1'b1,
                mk_result(ple_pkg::ST_OK, 2, 32'sh80000000));
        add_row(ple_pkg::ACT_READ,      '0, 0, 1'b1,
                mk_result(ple_pkg::ST_BADPOS, 2, '0));
        add_row(ple_pkg::ACT_READ,      '0, 3, 1'b1,
                mk_result(ple_pkg::ST_BADPOS, 2, '0));
        add_row(ple_pkg::ACT_READ,      '0, 255, 1'b1,
                mk_result(ple_pkg::ST_BADPOS, 2, '0));
        add_row(ple_pkg::ACT_INS_AT,    -32'sd1, 3, 1'b0, '0);
        add_row(ple_pkg::ACT_INS_AT,    '0, 1, 1'b0, '0);
        add_row(ple_pkg::ACT_DEL_AT,    '0, 0, 1'b1,
                mk_result(ple_pkg::ST_BADPOS, 4, '0));
        add_row(ple_pkg::ACT_DEL_AT,    '0, 5, 1'b1,
                mk_result(ple_pkg::ST_BADPOS, 4, '0));
        add_row(ACT_UNUSED,             32'sh55555555, 8'haa, 1'b1,
                mk_result(ple_pkg::ST_OK, 4, '0));
        add_row(ple_pkg::ACT_READ,      '0, 4, 1'b0, '0);
        add_row(ple_pkg::ACT_DEL_AT,    '0, 2, 1'b0, '0);
        add_row(ple_pkg::ACT_DEL_LAST,  '0, 0, 1'b0, '0);
        add_row(ple_pkg::ACT_DEL_FIRST, '0, 0, 1'b0, '0);
        add_row(ple_pkg::ACT_READ,      '0, 1, 1'b0, '0);
        add_row(ple_pkg::ACT_DEL_AT,    '0, 255, 1'b1,
                mk_result(ple_pkg::ST_BADPOS, 1, '0));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_q[i])
            offer(dir_q[i].act, dir_q[i].val, dir_q[i].pos, dir_q[i].typed, dir_q[i].fixed);

        for (int phase = 0; phase < 13; phase++) begin
            i_in_valid <= 1'b0;
            wait_drained();
            tx_idle_on = (phase % 4 != 3);
            rx_idle_on = (phase % 4 != 3);
            if (phase == 5) begin
                // long output stall while input keeps streaming
                tx_idle_on = 1'b0;
                rx_hold    = 150;
            end
            for (int k = 0; k < 100; k++) begin
                if (phase < 2)
                    offer_random(MIX_FILL);
                else if (phase % 5 == 2)
                    offer_random(MIX_DRAIN);
                else
                    offer_random($urandom_range(MIX_FILL, MIX_EVEN));
            end
        end
        i_in_valid <= 1'b0;
        wait_drained();
        repeat (10) @(posedge i_clk);

        if (mismatch_count == 0 && result_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
sv/ple_pkg.sv
sv/ple_cell.sv
sv/ple_ctrl.sv
sv/positional_list_engine_core.sv
tb/testbench.sv
